/* rtl/core/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// True peak detector package
// Sample and peak formats, interpolation filter taps and the transaction
// payload types shared by the true peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

   // Sample format is signed Q0.23 at the default width.
   localparam int SampleBits = 24;
   localparam int Channels   = 2;

   // Each channel keeps this many past samples for the four-tap window.
   localparam int HistDepth  = 3;
   localparam int NumPhases  = 4;
   localparam int NumTaps    = 4;

   // Filter taps are signed Q0.17.
   localparam int TapW       = 18;
   localparam int TapFrac    = 17;

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic        [SampleBits:0]   peak_type;
   typedef logic signed [TapW-1:0]       tap_type;

   localparam peak_type PeakMax = '1;

   // One row per interpolation phase, columns ordered oldest to newest sample.
   localparam tap_type TapSet [NumPhases][NumTaps] = '{
      '{-18'sd20436, 18'sd122616, 18'sd30654,  -18'sd13624},
      '{-18'sd28342, 18'sd99199,  18'sd66133,  -18'sd24800},
      '{-18'sd24800, 18'sd66133,  18'sd99199,  -18'sd28342},
      '{-18'sd13624, 18'sd30654,  18'sd122616, -18'sd20436}
   };

   typedef struct packed {
      logic       channel;
      sample_type sample;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic     out_channel;
      peak_type peak;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/core/true_peak_detector_unit.sv */
// ----------------------------------------------------------------------------
// True peak detector unit
// Per-channel block true peak with 4x polyphase interpolation between samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the req_ channel (valid/ready), each tagged with a channel
// and a last-of-block flag. Every sample is combined with the channel's three
// previous samples, four interpolated points are formed between the middle two,
// and the channel's running peak takes the largest magnitude seen. A sample
// flagged last produces one rsp_ transaction carrying the channel and its block
// peak (unsigned Q2.23, saturating), and the running peak of that channel
// starts over from zero. Other samples produce no transaction. A sample on a
// channel number at or above CHANNELS is dropped without effect.
// One sample is accepted every cycle while req_ready is high. A result appears
// on rsp_valid after its sample passes the window register, which loads on the
// accepting edge, then the product register, the magnitude register and the
// output register in turn. If the receiver holds rsp_ready low, the
// samples behind the waiting result keep flowing until a second last-of-block
// sample waits in the magnitude stage and the two stages behind it are full;
// req_ready then stays low until rsp_ready returns high. Reset clears the sample
// history, running peaks and all pipeline valid flags; the block is ready on
// the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module true_peak_detector_unit #(
   parameter int CHANNELS = tpd_pkg::Channels
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  tpd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output tpd_pkg::rsp_payload_type rsp_payload
);

   localparam int SB      = tpd_pkg::SampleBits;
   localparam int ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ProdW   = SB + tpd_pkg::TapW;
   localparam int AccW    = ProdW + 2;
   localparam int RndW    = AccW - tpd_pkg::TapFrac;
   localparam int NumMags = tpd_pkg::NumPhases + 1;
   localparam logic [AccW-1:0] RndHalf = AccW'(1) << (tpd_pkg::TapFrac - 1);
   localparam logic [RndW-1:0] RndMax  = RndW'(tpd_pkg::PeakMax);

   // Channel state.
   tpd_pkg::sample_type hist_ff [CHANNELS][tpd_pkg::HistDepth];
   tpd_pkg::peak_type   running_peak_ff [CHANNELS];

   // Stage 1: four-sample window.
   logic                s1_valid_ff;
   logic [ChIdxW-1:0]   s1_ch_ff;
   logic                s1_last_ff;
   tpd_pkg::sample_type s1_win_ff [tpd_pkg::NumTaps];

   // Stage 2: filter products and the new sample's magnitude.
   logic                    s2_valid_ff;
   logic [ChIdxW-1:0]       s2_ch_ff;
   logic                    s2_last_ff;
   logic signed [ProdW-1:0] s2_prod_ff [tpd_pkg::NumPhases][tpd_pkg::NumTaps];
   tpd_pkg::peak_type       s2_smag_ff;

   // Stage 3: all five magnitudes, the four interpolated ones rounded and saturated.
   logic              s3_valid_ff;
   logic [ChIdxW-1:0] s3_ch_ff;
   logic              s3_last_ff;
   tpd_pkg::peak_type s3_mag_ff [NumMags];

   // Output register.
   logic                     rsp_valid_ff;
   tpd_pkg::rsp_payload_type rsp_payload_ff;

   logic                     req_fire;
   logic                     ch_ok;
   logic [ChIdxW-1:0]        req_ch_idx;
   logic                     out_free;
   logic                     go3;
   logic                     s3_free;
   logic                     s2_free;
   logic                     s1_free;
   logic                     s1_valid_in;

   tpd_pkg::sample_type      s1_win_in [tpd_pkg::NumTaps];
   logic signed [ProdW-1:0]  s2_prod_in [tpd_pkg::NumPhases][tpd_pkg::NumTaps];
   logic signed [SB:0]       s2_wide_sample;
   tpd_pkg::peak_type        s2_smag_in;
   logic signed [AccW-1:0]   s3_acc [tpd_pkg::NumPhases];
   logic [AccW-1:0]          s3_abs [tpd_pkg::NumPhases];
   logic [AccW-1:0]          s3_rnd [tpd_pkg::NumPhases];
   logic [RndW-1:0]          s3_shift [tpd_pkg::NumPhases];
   tpd_pkg::peak_type        s3_mag_in [NumMags];
   tpd_pkg::peak_type        peak_in;

   // ------------------------------------------------------------------------
   // Handshake and pipeline flow. The magnitude stage can always retire a
   // non-last sample; only a last sample needs room in the output register.
   // ------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign go3        = s3_valid_ff && (!s3_last_ff || out_free);
   assign s3_free    = !s3_valid_ff || go3;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_ready  = s1_free;
   assign req_fire   = req_valid && req_ready;
   assign ch_ok      = (int'(req_payload.channel) < CHANNELS);
   assign req_ch_idx = ChIdxW'(req_payload.channel);
   assign s1_valid_in = req_fire && ch_ok;

   always_comb begin
      for (int k = 0; k < tpd_pkg::HistDepth; k++) begin
         s1_win_in[k] = hist_ff[req_ch_idx][k];
      end
      s1_win_in[tpd_pkg::HistDepth] = req_payload.sample;
   end

   // ------------------------------------------------------------------------
   // Stage 2 inputs: constant-coefficient products.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < tpd_pkg::NumPhases; j++) begin
         for (int k = 0; k < tpd_pkg::NumTaps; k++) begin
            s2_prod_in[j][k] = ProdW'(s1_win_ff[k]) * ProdW'(tpd_pkg::TapSet[j][k]);
         end
      end
   end

   // The most negative sample has magnitude 2^(SB-1), which the extra bit holds.
   assign s2_wide_sample = (SB + 1)'(s1_win_ff[tpd_pkg::NumTaps - 1]);
   assign s2_smag_in     = s2_wide_sample[SB] ? tpd_pkg::peak_type'(-s2_wide_sample)
                                              : tpd_pkg::peak_type'(s2_wide_sample);

   // ------------------------------------------------------------------------
   // Stage 3 inputs: sum, magnitude, round half away from zero, saturate.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < tpd_pkg::NumPhases; j++) begin
         s3_acc[j] = AccW'(s2_prod_ff[j][0]) + AccW'(s2_prod_ff[j][1])
                   + AccW'(s2_prod_ff[j][2]) + AccW'(s2_prod_ff[j][3]);
         s3_abs[j] = s3_acc[j][AccW-1] ? AccW'(-s3_acc[j]) : AccW'(s3_acc[j]);
         s3_rnd[j] = s3_abs[j] + RndHalf;
         s3_shift[j] = s3_rnd[j][AccW-1:tpd_pkg::TapFrac];
         if (s3_shift[j] > RndMax) begin
            s3_mag_in[j] = tpd_pkg::PeakMax;
         end else begin
            s3_mag_in[j] = s3_shift[j][SB:0];
         end
      end
      s3_mag_in[tpd_pkg::NumPhases] = s2_smag_ff;
   end

   // ------------------------------------------------------------------------
   // Peak update: largest of the running peak and the five new magnitudes.
   // ------------------------------------------------------------------------
   always_comb begin
      peak_in = running_peak_ff[s3_ch_ff];
      for (int i = 0; i < NumMags; i++) begin
         if (s3_mag_ff[i] > peak_in) begin
            peak_in = s3_mag_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            running_peak_ff[c] <= '0;
            for (int k = 0; k < tpd_pkg::HistDepth; k++) begin
               hist_ff[c][k] <= '0;
            end
         end
      end else begin
         if (s1_valid_in) begin
            for (int k = 0; k < tpd_pkg::HistDepth; k++) begin
               hist_ff[req_ch_idx][k] <= s1_win_in[k + 1];
            end
         end
         if (s1_free) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (go3) begin
            running_peak_ff[s3_ch_ff] <= s3_last_ff ? '0 : peak_in;
         end
         if (go3 && s3_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ch_ff   <= req_ch_idx;
         s1_last_ff <= req_payload.last;
         s1_win_ff  <= s1_win_in;
      end
      if (s2_free) begin
         s2_ch_ff   <= s1_ch_ff;
         s2_last_ff <= s1_last_ff;
         s2_prod_ff <= s2_prod_in;
         s2_smag_ff <= s2_smag_in;
      end
      if (s3_free) begin
         s3_ch_ff   <= s2_ch_ff;
         s3_last_ff <= s2_last_ff;
         s3_mag_ff  <= s3_mag_in;
      end
      if (go3 && s3_last_ff) begin
         rsp_payload_ff.out_channel <= s3_ch_ff[0];
         rsp_payload_ff.peak        <= peak_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* tb/true_peak_detector_unit_tb.sv */
// ----------------------------------------------------------------------------
// True peak detector unit testbench
// Sends a short table of hand-picked samples and then a long random stream
// through the req_ channel, predicts each block peak with its own 4x
// interpolation model and checks every rsp_ transaction in order. Both sides
// idle in random bursts except during the final stretch of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module true_peak_detector_unit_tb;

   localparam int RandomItems = 1200;
   localparam int CalmItems   = 150;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 8;
   localparam int RoundShift  = 17;
   localparam int ReportLimit = 10;
   localparam int DirectedRows = 23;

   // Interpolation taps in Q0.17, one row per phase, oldest sample first.
   localparam longint InterpTap [4][4] = '{
      '{-20436, 122616,  30654, -13624},
      '{-28342,  99199,  66133, -24800},
      '{-24800,  66133,  99199, -28342},
      '{-13624,  30654, 122616, -20436}
   };

   localparam int IdlePct [4] = '{0, 5, 15, 40};

   typedef struct packed {
      logic                     has_known;
      tpd_pkg::peak_type        known_peak;
      tpd_pkg::req_payload_type item;
   } directed_row_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   tpd_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   tpd_pkg::rsp_payload_type rsp_payload;

   tpd_pkg::sample_type      past_sample [tpd_pkg::Channels][tpd_pkg::HistDepth];
   tpd_pkg::peak_type        block_peak [tpd_pkg::Channels];
   bit                       swing_high [tpd_pkg::Channels];
   tpd_pkg::rsp_payload_type peak_queue [$];

   int mismatch_count = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int stall_left     = 0;
   int stall_cycles   = 0;
   bit calm           = 1'b0;

   // Known peaks only appear on rows taken straight after reset.
   directed_row_type directed_rows [DirectedRows] = '{
      '{1'b1, 25'd0,       '{1'b0, 24'sh000000, 1'b1}},
      '{1'b1, 25'd8388608, '{1'b1, 24'sh800000, 1'b1}},
      '{1'b1, 25'd8388607, '{1'b0, 24'sh7FFFFF, 1'b1}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh800000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh7FFFFF, 1'b0}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh800000, 1'b1}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000001, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'shFFFFFF, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000000, 1'b1}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh000000, 1'b1}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000000, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh000000, 1'b1}},
      '{1'b0, 25'd0,       '{1'b0, 24'sh003039, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'shFFEDCC, 1'b1}},
      '{1'b0, 25'd0,       '{1'b0, 24'shFFFFFF, 1'b1}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh555555, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'shAAAAAA, 1'b0}},
      '{1'b0, 25'd0,       '{1'b1, 24'sh7FFFFF, 1'b1}}
   };

   true_peak_detector_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   function automatic tpd_pkg::peak_type clip_magnitude(input longint unsigned m);
      return (m > tpd_pkg::PeakMax) ? tpd_pkg::PeakMax : tpd_pkg::peak_type'(m);
   endfunction

   // Advances one channel by one sample and returns 1 when the block closes.
   function automatic bit predict_block_peak(input tpd_pkg::req_payload_type item,
                                             output tpd_pkg::rsp_payload_type report);
      longint            window [4];
      longint            acc;
      longint unsigned   m;
      tpd_pkg::peak_type pk;
      tpd_pkg::peak_type point;
      int                ch;
      ch     = int'(item.channel);
      report = '0;
      if (ch >= tpd_pkg::Channels) return 1'b0;
      for (int k = 0; k < 3; k++) window[k] = longint'(past_sample[ch][k]);
      window[3] = longint'(item.sample);
      pk = block_peak[ch];
      m  = (window[3] < 0) ? -window[3] : window[3];
      point = clip_magnitude(m);
      if (point > pk) pk = point;
      for (int j = 0; j < 4; j++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) acc += InterpTap[j][k] * window[k];
         m = (acc < 0) ? -acc : acc;
         m = (m + (64'd1 << (RoundShift - 1))) >> RoundShift;
         point = clip_magnitude(m);
         if (point > pk) pk = point;
      end
      past_sample[ch][0] = past_sample[ch][1];
      past_sample[ch][1] = past_sample[ch][2];
      past_sample[ch][2] = item.sample;
      if (item.last) begin
         report.out_channel = item.channel;
         report.peak        = pk;
         block_peak[ch]     = '0;
         return 1'b1;
      end
      block_peak[ch] = pk;
      return 1'b0;
   endfunction

   // Mixes full-range noise with extremes, small values and full-scale
   // swings that alternate in sign to push the interpolated points past
   // full scale.
   function automatic tpd_pkg::sample_type random_sample(input logic ch);
      tpd_pkg::sample_type s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: s = 24'sh800000;
               1: s = 24'sh7FFFFF;
               2: s = '0;
               3: s = '1;
               default: s = 24'sh000001;
            endcase
         end
         1, 2: s = tpd_pkg::sample_type'(int'($urandom_range(0, 511)) - 256);
         3, 4: begin
            swing_high[ch] = !swing_high[ch];
            s = swing_high[ch]
                ? tpd_pkg::sample_type'(32'h7FFFFF - $urandom_range(0, 4095))
                : tpd_pkg::sample_type'(32'h800000 + $urandom_range(0, 4095));
         end
         default: s = tpd_pkg::sample_type'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_sample(input tpd_pkg::req_payload_type item, input bit has_known,
                              input tpd_pkg::peak_type known_peak);
      tpd_pkg::rsp_payload_type report;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_block_peak(item, report)) begin
         if (has_known) report.peak = known_peak;
         peak_queue.push_back(report);
      end
   endtask

   initial begin
      tpd_pkg::req_payload_type item;
      for (int c = 0; c < tpd_pkg::Channels; c++) begin
         for (int k = 0; k < tpd_pkg::HistDepth; k++) past_sample[c][k] = '0;
         block_peak[c] = '0;
         swing_high[c] = 1'b0;
      end
      wait (reset == 1'b0);
      @(posedge clock);
      gap_pct = IdlePct[$urandom_range(0, 3)];
      for (int r = 0; r < DirectedRows; r++) begin
         send_sample(directed_rows[r].item, directed_rows[r].has_known,
                     directed_rows[r].known_peak);
      end
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 100 == 0) gap_pct = IdlePct[$urandom_range(0, 3)];
         if (n == RandomItems - CalmItems) calm = 1'b1;
         item.channel = 1'($urandom_range(0, 1));
         item.sample  = random_sample(item.channel);
         item.last    = ($urandom_range(0, 7) == 0);
         send_sample(item, 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (peak_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   always @(posedge clock) begin
      stall_cycles++;
      if (stall_cycles % 400 == 0) stall_pct = IdlePct[$urandom_range(0, 3)];
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && !reset && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tpd_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (peak_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected peak transaction: channel %0d peak %0d",
                        rsp_payload.out_channel, rsp_payload.peak);
         end else begin
            want = peak_queue.pop_front();
            if (rsp_payload.out_channel !== want.out_channel ||
                rsp_payload.peak !== want.peak) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("peak mismatch: expected channel %0d peak %0d, got channel %0d peak %0d",
                           want.out_channel, want.peak,
                           rsp_payload.out_channel, rsp_payload.peak);
            end
         end
      end
   end

endmodule

`default_nettype wire
